/* rtl/sfla_pkg.sv */
package sfla_pkg;

	localparam int HEAP_BYTES  = 65536;
	localparam int NUM_CLASSES = 13;
	localparam int CHUNK_BYTES = 256;

	localparam int LAST_CLASS  = NUM_CLASSES - 1;
	localparam int STORE_WORDS = HEAP_BYTES / 4;
	localparam int MEM_AW      = $clog2(STORE_WORDS);
	localparam int CLS_W       = $clog2(NUM_CLASSES);
	localparam int WALK_LIMIT  = HEAP_BYTES / 16 + 1;
	localparam int WALK_W      = $clog2(WALK_LIMIT + 1);
	localparam int HEND_W      = $clog2(HEAP_BYTES + 1);

	localparam logic [31:0] SPLIT_MIN    = 32'd24;
	localparam logic [31:0] PROLOGUE_TAG = 32'd9;
	localparam logic [31:0] EPILOGUE_TAG = 32'd1;
	localparam logic [HEND_W-1:0] INIT_END = HEND_W'(16);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [15:0] req_size;
		logic [15:0] block_addr;
	} req_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [5:0] {
		S_INIT, S_IDLE, S_DONE,
		S_FR0, S_FR1, S_FR2, S_FR3, S_FR4,
		S_FH, S_FCHK, S_FNX, S_FCLS, S_AX,
		S_PL0, S_PL1, S_PL2, S_PL3, S_PL4, S_PL5, S_PL6, S_PLD,
		S_UL0, S_UL1, S_UL2, S_UL3, S_UL4,
		S_LK0, S_LK1, S_LK2,
		S_E0, S_E1, S_E2, S_E3, S_E4,
		S_C0, S_C1, S_C2, S_C3, S_C4, S_C5,
		S_FP, S_FPC, S_FN, S_FNC,
		S_P3, S_P4, S_P5,
		S_A3, S_A5, S_A6, S_A7,
		S_N3, S_N5, S_N7, S_N8, S_N9,
		S_CL
	} state_t;

	// size class: halve while above the split minimum, capped at the last list
	function automatic logic [CLS_W-1:0] class_of(input logic [31:0] size);
		logic [CLS_W-1:0] c;
		c = CLS_W'(LAST_CLASS);
		for (int i = LAST_CLASS - 1; i >= 0; i--) begin
			if ((size >> i) <= SPLIT_MIN) begin
				c = CLS_W'(i);
			end
		end
		return c;
	endfunction

	// prologue and initial epilogue words written after reset
	function automatic logic [31:0] init_word(input logic [1:0] idx);
		logic [31:0] w;
		case (idx)
			2'd1, 2'd2: w = PROLOGUE_TAG;
			2'd3:       w = EPILOGUE_TAG;
			default:    w = 32'd0;
		endcase
		return w;
	endfunction

endpackage

/* rtl/segregated_free_list_allocator_unit.sv */
// segregated free-list heap allocator, one transaction at a time
// zero-size allocates and null frees answer without touching the heap; an allocate walks its
// first class, then each extra node or empty class, unlinks the first block that fits and splits
// it when the remainder is large enough; a free clears the alloc bits, pushes the block and merges
// it with free neighbors; a miss scans all classes and the heap extension adds at least a chunk
// the block takes a new transaction only in idle, once the last result is in the output register
// reset: list heads clear at once, then the prologue, epilogue and first chunk are written
module segregated_free_list_allocator_unit import sfla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// heap word store, byte addresses map to words by dropping the low two bits
	logic [31:0] heap_mem [STORE_WORDS];
	logic [31:0] mem_rdata_q;
	logic        mem_we;
	logic [31:0] mem_waddr, mem_wdata, mem_raddr;

	// free list heads, one read port shared by the list walk and list insert
	logic [31:0]      heads_q [NUM_CLASSES];
	logic             hd_we;
	logic [CLS_W-1:0] hd_widx, hd_ridx;
	logic [31:0]      hd_wdata, hd_rdata;

	// sequencer with return registers for the shared subroutines
	state_t state_q, state_d;
	state_t ret_q, ret_d;     // unlink / link return
	state_t fret_q, fret_d;   // neighbor address fetch return
	state_t cret_q, cret_d;   // coalesce return
	state_t eret_q, eret_d;   // extend return
	logic [1:0] init_q, init_d;
	logic [HEND_W-1:0] heap_end_q, heap_end_d;
	logic rsp_valid_q, rsp_load;

	// datapath registers
	logic [31:0] cbp_q, cbp_d, t_q, t_d, ns_q, ns_d, csz_q, csz_d;
	logic [31:0] prv_q, prv_d, nxt_q, nxt_d, prvhs_q, prvhs_d, nxtsz_q, nxtsz_d;
	logic        na_q, na_d;
	logic [31:0] ubp_q, ubp_d, us_q, us_d, up_q, up_d;
	logic [CLS_W-1:0] ucls_q, ucls_d, fcls_q, fcls_d;
	logic [31:0] lbp_q, lbp_d, lsz_q, lsz_d, lh_q, lh_d;
	logic [31:0] asize_q, asize_d, fb_q, fb_d;
	logic [WALK_W-1:0] fn_q, fn_d, fn_inc;
	logic [31:0] pbp_q, pbp_d, pcs_q, pcs_d, prem_q, prem_d, pnb_q, pnb_d;
	logic [31:0] eb_q, eb_d, esz_q, esz_d, ebp_q, ebp_d;
	logic        eok_q, eok_d;
	rsp_t        res_q, res_d;

	// helpers
	logic [31:0] dsz;
	logic [31:0] e_words, e_size, e_room;
	logic [31:0] req_asize;
	logic [CLS_W-1:0] lk_cls;

	assign dsz       = {mem_rdata_q[31:3], 3'b000};
	assign e_words   = eb_q >> 2;
	assign e_size    = (e_words + {31'b0, e_words[0]}) << 2;
	assign e_room    = 32'(HEAP_BYTES) - 32'(heap_end_q);
	assign req_asize = (req.req_size <= 16'd8) ? 32'd16
	                 : ((32'(req.req_size) + 32'd15) & ~32'd7);
	assign lk_cls    = class_of(lsz_q);
	assign fn_inc    = fn_q + WALK_W'(1);
	assign hd_ridx   = (state_q == S_FH) ? fcls_q : lk_cls;
	assign hd_rdata  = heads_q[hd_ridx];

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// memory: synchronous write at one address, registered read at another
	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem[mem_waddr[MEM_AW+1:2]] <= mem_wdata;
		end
		mem_rdata_q <= heap_mem[mem_raddr[MEM_AW+1:2]];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			ret_q       <= S_IDLE;
			fret_q      <= S_IDLE;
			cret_q      <= S_IDLE;
			eret_q      <= S_IDLE;
			init_q      <= '0;
			heap_end_q  <= INIT_END;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				heads_q[i] <= '0;
			end
		end else begin
			state_q    <= state_d;
			ret_q      <= ret_d;
			fret_q     <= fret_d;
			cret_q     <= cret_d;
			eret_q     <= eret_d;
			init_q     <= init_d;
			heap_end_q <= heap_end_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (hd_we) begin
				heads_q[hd_widx] <= hd_wdata;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cbp_q <= cbp_d;  t_q <= t_d;  ns_q <= ns_d;  csz_q <= csz_d;
		prv_q <= prv_d;  nxt_q <= nxt_d;  prvhs_q <= prvhs_d;  nxtsz_q <= nxtsz_d;
		na_q <= na_d;
		ubp_q <= ubp_d;  us_q <= us_d;  up_q <= up_d;  ucls_q <= ucls_d;
		lbp_q <= lbp_d;  lsz_q <= lsz_d;  lh_q <= lh_d;
		asize_q <= asize_d;  fcls_q <= fcls_d;  fb_q <= fb_d;  fn_q <= fn_d;
		pbp_q <= pbp_d;  pcs_q <= pcs_d;  prem_q <= prem_d;  pnb_q <= pnb_d;
		eb_q <= eb_d;  esz_q <= esz_d;  ebp_q <= ebp_d;  eok_q <= eok_d;
		res_q <= res_d;
		if (rsp_load) begin
			rsp <= res_q;
		end
	end

	always_comb begin
		state_d = state_q;  ret_d = ret_q;  fret_d = fret_q;  cret_d = cret_q;
		eret_d = eret_q;  init_d = init_q;  heap_end_d = heap_end_q;
		cbp_d = cbp_q;  t_d = t_q;  ns_d = ns_q;  csz_d = csz_q;
		prv_d = prv_q;  nxt_d = nxt_q;  prvhs_d = prvhs_q;  nxtsz_d = nxtsz_q;
		na_d = na_q;
		ubp_d = ubp_q;  us_d = us_q;  up_d = up_q;  ucls_d = ucls_q;
		lbp_d = lbp_q;  lsz_d = lsz_q;  lh_d = lh_q;
		asize_d = asize_q;  fcls_d = fcls_q;  fb_d = fb_q;  fn_d = fn_q;
		pbp_d = pbp_q;  pcs_d = pcs_q;  prem_d = prem_q;  pnb_d = pnb_q;
		eb_d = eb_q;  esz_d = esz_q;  ebp_d = ebp_q;  eok_d = eok_q;
		res_d = res_q;
		mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_raddr = '0;
		hd_we = 1'b0;  hd_widx = '0;  hd_wdata = '0;
		rsp_load = 1'b0;

		unique case (state_q)
			// prologue, then the first chunk through the normal extend path
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = 32'(init_q) << 2;
				mem_wdata = init_word(init_q);
				init_d    = init_q + 2'd1;
				if (init_q == 2'd3) begin
					heap_end_d = INIT_END;
					eb_d       = 32'(CHUNK_BYTES);
					eret_d     = S_IDLE;
					state_d    = S_E0;
				end
			end

			S_IDLE: begin
				if (req_valid) begin
					if (req.cmd == CMD_FREE) begin
						if (req.block_addr == 16'd0) begin
							res_d   = '{addr: 16'd0, status: STAT_OK};
							state_d = S_DONE;
						end else begin
							cbp_d   = 32'(req.block_addr);
							state_d = S_FR0;
						end
					end else if (req.req_size == 16'd0) begin
						res_d   = '{addr: 16'd0, status: STAT_ZERO};
						state_d = S_DONE;
					end else begin
						asize_d = req_asize;
						fcls_d  = class_of(req_asize);
						state_d = S_FH;
					end
				end
			end

			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end

			// free: clear alloc bits, push, coalesce
			S_FR0: begin
				mem_raddr = cbp_q - 32'd4;
				state_d   = S_FR1;
			end
			S_FR1: begin
				csz_d     = dsz;
				mem_we    = 1'b1;
				mem_waddr = cbp_q - 32'd4;
				mem_wdata = dsz;
				state_d   = S_FR2;
			end
			S_FR2: begin
				mem_we    = 1'b1;
				mem_waddr = cbp_q + csz_q - 32'd8;
				mem_wdata = csz_q;
				lbp_d     = cbp_q;
				lsz_d     = csz_q;
				ret_d     = S_FR3;
				state_d   = S_LK0;
			end
			S_FR3: begin
				cret_d  = S_FR4;
				state_d = S_C0;
			end
			S_FR4: begin
				res_d   = '{addr: 16'd0, status: STAT_OK};
				state_d = S_DONE;
			end

			// first-fit walk over the classes
			S_FH: begin
				if (hd_rdata != 32'd0) begin
					fb_d      = hd_rdata;
					fn_d      = '0;
					mem_raddr = hd_rdata - 32'd4;
					state_d   = S_FCHK;
				end else begin
					state_d = S_FCLS;
				end
			end
			S_FCHK: begin
				if (asize_q <= dsz) begin
					pbp_d   = fb_q;
					state_d = S_PL0;
				end else begin
					mem_raddr = fb_q;
					state_d   = S_FNX;
				end
			end
			S_FNX: begin
				fb_d = mem_rdata_q;
				fn_d = fn_inc;
				if (mem_rdata_q != 32'd0 && fn_inc < WALK_W'(WALK_LIMIT)) begin
					mem_raddr = mem_rdata_q - 32'd4;
					state_d   = S_FCHK;
				end else begin
					state_d = S_FCLS;
				end
			end
			S_FCLS: begin
				if (fcls_q == CLS_W'(LAST_CLASS)) begin
					eb_d    = (asize_q > 32'(CHUNK_BYTES)) ? asize_q : 32'(CHUNK_BYTES);
					eret_d  = S_AX;
					state_d = S_E0;
				end else begin
					fcls_d  = fcls_q + CLS_W'(1);
					state_d = S_FH;
				end
			end
			S_AX: begin
				if (!eok_q) begin
					res_d   = '{addr: 16'd0, status: STAT_FULL};
					state_d = S_DONE;
				end else begin
					pbp_d   = cbp_q;
					state_d = S_PL0;
				end
			end

			// place: unlink, then split or take whole
			S_PL0: begin
				mem_raddr = pbp_q - 32'd4;
				state_d   = S_PL1;
			end
			S_PL1: begin
				pcs_d   = dsz;
				prem_d  = dsz - asize_q;
				pnb_d   = pbp_q + asize_q;
				ubp_d   = pbp_q;
				ret_d   = S_PL2;
				state_d = S_UL0;
			end
			S_PL2: begin
				mem_we    = 1'b1;
				mem_waddr = pbp_q - 32'd4;
				if (prem_q > SPLIT_MIN) begin
					mem_wdata = asize_q | 32'd1;
					state_d   = S_PL3;
				end else begin
					mem_wdata = pcs_q | 32'd1;
					state_d   = S_PL6;
				end
			end
			S_PL3: begin
				mem_we    = 1'b1;
				mem_waddr = pnb_q - 32'd8;
				mem_wdata = asize_q | 32'd1;
				state_d   = S_PL4;
			end
			S_PL4: begin
				mem_we    = 1'b1;
				mem_waddr = pnb_q - 32'd4;
				mem_wdata = prem_q;
				state_d   = S_PL5;
			end
			S_PL5: begin
				mem_we    = 1'b1;
				mem_waddr = pnb_q + prem_q - 32'd8;
				mem_wdata = prem_q;
				lbp_d     = pnb_q;
				lsz_d     = prem_q;
				ret_d     = S_PLD;
				state_d   = S_LK0;
			end
			S_PL6: begin
				mem_we    = 1'b1;
				mem_waddr = pbp_q + pcs_q - 32'd8;
				mem_wdata = pcs_q | 32'd1;
				state_d   = S_PLD;
			end
			S_PLD: begin
				res_d   = '{addr: pbp_q[15:0], status: STAT_OK};
				state_d = S_DONE;
			end

			// unlink ubp from its list
			S_UL0: begin
				mem_raddr = ubp_q - 32'd4;
				state_d   = S_UL1;
			end
			S_UL1: begin
				ucls_d    = class_of(dsz);
				mem_raddr = ubp_q;
				state_d   = S_UL2;
			end
			S_UL2: begin
				us_d      = mem_rdata_q;
				mem_raddr = ubp_q + 32'd4;
				state_d   = S_UL3;
			end
			S_UL3: begin
				up_d = mem_rdata_q;
				if (mem_rdata_q != 32'd0) begin
					mem_we    = 1'b1;
					mem_waddr = mem_rdata_q;
					mem_wdata = us_q;
					state_d   = (us_q != 32'd0) ? S_UL4 : ret_q;
				end else begin
					mem_we    = (us_q != 32'd0);
					mem_waddr = us_q + 32'd4;
					mem_wdata = 32'd0;
					hd_we     = 1'b1;
					hd_widx   = ucls_q;
					hd_wdata  = us_q;
					state_d   = ret_q;
				end
			end
			S_UL4: begin
				mem_we    = 1'b1;
				mem_waddr = us_q + 32'd4;
				mem_wdata = up_q;
				state_d   = ret_q;
			end

			// push lbp onto the head of its list
			S_LK0: begin
				lh_d      = hd_rdata;
				hd_we     = 1'b1;
				hd_widx   = lk_cls;
				hd_wdata  = lbp_q;
				mem_we    = 1'b1;
				mem_waddr = lbp_q + 32'd4;
				mem_wdata = 32'd0;
				state_d   = S_LK1;
			end
			S_LK1: begin
				mem_we    = 1'b1;
				mem_waddr = lbp_q;
				mem_wdata = lh_q;
				state_d   = (lh_q != 32'd0) ? S_LK2 : ret_q;
			end
			S_LK2: begin
				mem_we    = 1'b1;
				mem_waddr = lh_q + 32'd4;
				mem_wdata = lbp_q;
				state_d   = ret_q;
			end

			// grow the heap at heap_end
			S_E0: begin
				if (e_size > e_room) begin
					eok_d   = 1'b0;
					state_d = eret_q;
				end else begin
					esz_d     = e_size;
					ebp_d     = 32'(heap_end_q);
					mem_we    = 1'b1;
					mem_waddr = 32'(heap_end_q) - 32'd4;
					mem_wdata = e_size;
					state_d   = S_E1;
				end
			end
			S_E1: begin
				mem_we    = 1'b1;
				mem_waddr = ebp_q + esz_q - 32'd8;
				mem_wdata = esz_q;
				state_d   = S_E2;
			end
			S_E2: begin
				mem_we     = 1'b1;
				mem_waddr  = ebp_q + esz_q - 32'd4;
				mem_wdata  = EPILOGUE_TAG;
				heap_end_d = heap_end_q + esz_q[HEND_W-1:0];
				lbp_d      = ebp_q;
				lsz_d      = esz_q;
				ret_d      = S_E3;
				state_d    = S_LK0;
			end
			S_E3: begin
				cbp_d   = ebp_q;
				cret_d  = S_E4;
				state_d = S_C0;
			end
			S_E4: begin
				eok_d   = 1'b1;
				state_d = eret_q;
			end

			// coalesce cbp with free neighbors, result left in cbp
			S_C0: begin
				mem_raddr = cbp_q - 32'd8;
				state_d   = S_C1;
			end
			S_C1: begin
				prv_d     = cbp_q - dsz;
				mem_raddr = cbp_q - 32'd4;
				state_d   = S_C2;
			end
			S_C2: begin
				csz_d     = dsz;
				nxt_d     = cbp_q + dsz;
				mem_raddr = prv_q - 32'd4;
				state_d   = S_C3;
			end
			S_C3: begin
				prvhs_d   = dsz;
				mem_raddr = nxt_q - 32'd4;
				state_d   = S_C4;
			end
			S_C4: begin
				nxtsz_d   = dsz;
				na_d      = mem_rdata_q[0];
				mem_raddr = prv_q + prvhs_q - 32'd8;
				state_d   = S_C5;
			end
			S_C5: begin
				ubp_d = cbp_q;
				if (mem_rdata_q[0] && na_q) begin
					state_d = cret_q;
				end else if (mem_rdata_q[0]) begin
					// merge with the following block
					ns_d    = csz_q + nxtsz_q;
					ret_d   = S_FN;
					fret_d  = S_P3;
					state_d = S_UL0;
				end else if (na_q) begin
					// merge with the preceding block
					ns_d    = csz_q + prvhs_q;
					ret_d   = S_FP;
					fret_d  = S_A3;
					state_d = S_UL0;
				end else begin
					// merge both sides
					ns_d    = csz_q + prvhs_q + nxtsz_q;
					ret_d   = S_FP;
					fret_d  = S_N3;
					state_d = S_UL0;
				end
			end

			// neighbor address fetch into t
			S_FP: begin
				mem_raddr = cbp_q - 32'd8;
				state_d   = S_FPC;
			end
			S_FPC: begin
				t_d     = cbp_q - dsz;
				state_d = fret_q;
			end
			S_FN: begin
				mem_raddr = cbp_q - 32'd4;
				state_d   = S_FNC;
			end
			S_FNC: begin
				t_d     = cbp_q + dsz;
				state_d = fret_q;
			end

			S_P3: begin
				ubp_d   = t_q;
				ret_d   = S_P4;
				state_d = S_UL0;
			end
			S_P4: begin
				mem_we    = 1'b1;
				mem_waddr = cbp_q - 32'd4;
				mem_wdata = ns_q;
				state_d   = S_P5;
			end
			S_P5: begin
				mem_we    = 1'b1;
				mem_waddr = cbp_q + (ns_q & ~32'd7) - 32'd8;
				mem_wdata = ns_q;
				lbp_d     = cbp_q;
				lsz_d     = ns_q;
				ret_d     = cret_q;
				state_d   = S_LK0;
			end

			S_A3: begin
				ubp_d   = t_q;
				ret_d   = S_FP;
				fret_d  = S_A5;
				state_d = S_UL0;
			end
			S_A5: begin
				mem_we    = 1'b1;
				mem_waddr = t_q - 32'd4;
				mem_wdata = ns_q;
				state_d   = S_A6;
			end
			S_A6: begin
				mem_raddr = cbp_q - 32'd4;
				state_d   = S_A7;
			end
			S_A7: begin
				mem_we    = 1'b1;
				mem_waddr = cbp_q + dsz - 32'd8;
				mem_wdata = ns_q;
				fret_d    = S_CL;
				state_d   = S_FP;
			end

			S_N3: begin
				ubp_d   = t_q;
				ret_d   = S_FN;
				fret_d  = S_N5;
				state_d = S_UL0;
			end
			S_N5: begin
				ubp_d   = t_q;
				ret_d   = S_FP;
				fret_d  = S_N7;
				state_d = S_UL0;
			end
			S_N7: begin
				mem_we    = 1'b1;
				mem_waddr = t_q - 32'd4;
				mem_wdata = ns_q;
				fret_d    = S_N8;
				state_d   = S_FN;
			end
			S_N8: begin
				mem_raddr = t_q - 32'd4;
				state_d   = S_N9;
			end
			S_N9: begin
				mem_we    = 1'b1;
				mem_waddr = t_q + dsz - 32'd8;
				mem_wdata = ns_q;
				fret_d    = S_CL;
				state_d   = S_FP;
			end

			// merged block starts at the preceding one
			S_CL: begin
				cbp_d   = t_q;
				lbp_d   = t_q;
				lsz_d   = ns_q;
				ret_d   = cret_q;
				state_d = S_LK0;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// heap never grows past its store
	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(heap_end_q) <= 32'(HEAP_BYTES))
		else $error("heap end beyond store");

	// heap end stays double-word aligned
	a_heap_align: assert property (@(posedge clk) disable iff (!arst_n)
		heap_end_q[2:0] == 3'b000)
		else $error("heap end misaligned");

	// sequencer leaves idle only on an accepted transaction
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !req_valid) |=> state_q == S_IDLE)
		else $error("left idle without a transaction");

	// a finished result waits while the output register is still occupied
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && !rsp_ready) |=> state_q == S_DONE)
		else $error("result overwrote pending output");

endmodule

/* tb/tb_sfla_checker.sv */
module tb_sfla_checker import sfla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] heap_mem [0:STORE_WORDS-1];
	logic [31:0] list_head [0:NUM_CLASSES-1];
	logic [31:0] heap_top;
	rsp_t expected_rsp [$];

	function automatic logic [31:0] mem_rd(input logic [31:0] a);
		return heap_mem[a[MEM_AW+1:2]];
	endfunction

	function automatic void mem_wr(input logic [31:0] a, input logic [31:0] v);
		heap_mem[a[MEM_AW+1:2]] = v;
	endfunction

	function automatic logic [31:0] blk_size(input logic [31:0] bp);
		return mem_rd(bp - 32'd4) & ~32'd7;
	endfunction

	function automatic logic [31:0] next_blk(input logic [31:0] bp);
		return bp + blk_size(bp);
	endfunction

	function automatic logic [31:0] prev_blk(input logic [31:0] bp);
		return bp - (mem_rd(bp - 32'd8) & ~32'd7);
	endfunction

	function automatic int size_class(input logic [31:0] size);
		int c;
		logic [31:0] s;
		c = 0;
		s = size;
		while (c < LAST_CLASS && s > SPLIT_MIN) begin
			s = s >> 1;
			c++;
		end
		return c;
	endfunction

	function automatic void push_free(input logic [31:0] bp, input logic [31:0] size);
		int c;
		logic [31:0] h;
		c = size_class(size);
		h = list_head[c];
		list_head[c] = bp;
		mem_wr(bp + 32'd4, 32'd0);
		mem_wr(bp, h);
		if (h != 0) mem_wr(h + 32'd4, bp);
	endfunction

	function automatic void pull_free(input logic [31:0] bp);
		int c;
		logic [31:0] s, p;
		c = size_class(blk_size(bp));
		s = mem_rd(bp);
		p = mem_rd(bp + 32'd4);
		if (p != 0) begin
			mem_wr(p, s);
			if (s != 0) mem_wr(s + 32'd4, p);
		end else begin
			if (s != 0) mem_wr(s + 32'd4, 32'd0);
			list_head[c] = s;
		end
	endfunction

	function automatic logic [31:0] merge_free(input logic [31:0] bp_in);
		logic [31:0] bp, prv, size, nb;
		logic pa, na;
		bp = bp_in;
		prv = prev_blk(bp);
		pa = 1'(mem_rd(prv + blk_size(prv) - 32'd8) & 32'd1);
		na = 1'(mem_rd(next_blk(bp) - 32'd4) & 32'd1);
		size = blk_size(bp);
		if (pa && na) return bp;
		if (pa) begin
			size += blk_size(next_blk(bp));
			pull_free(bp);
			pull_free(next_blk(bp));
			mem_wr(bp - 32'd4, size);
			mem_wr(bp + blk_size(bp) - 32'd8, size);
		end else if (na) begin
			size += blk_size(prev_blk(bp));
			pull_free(bp);
			pull_free(prev_blk(bp));
			mem_wr(prev_blk(bp) - 32'd4, size);
			mem_wr(bp + blk_size(bp) - 32'd8, size);
			bp = prev_blk(bp);
		end else begin
			size += blk_size(prev_blk(bp)) + blk_size(next_blk(bp));
			pull_free(bp);
			pull_free(prev_blk(bp));
			pull_free(next_blk(bp));
			mem_wr(prev_blk(bp) - 32'd4, size);
			nb = next_blk(bp);
			mem_wr(nb + blk_size(nb) - 32'd8, size);
			bp = prev_blk(bp);
		end
		push_free(bp, size);
		return bp;
	endfunction

	function automatic logic [31:0] grow_heap(input logic [31:0] bytes);
		logic [31:0] words, size, bp;
		words = bytes / 4;
		size = words[0] ? (words + 1) * 4 : words * 4;
		if (size > HEAP_BYTES - heap_top) return 32'd0;
		bp = heap_top;
		mem_wr(bp - 32'd4, size);
		mem_wr(bp + size - 32'd8, size);
		mem_wr(bp + size - 32'd4, 32'd1);
		heap_top += size;
		push_free(bp, size);
		return merge_free(bp);
	endfunction

	function automatic logic [31:0] first_fit(input logic [31:0] asize);
		logic [31:0] b;
		int n;
		for (int c = size_class(asize); c <= LAST_CLASS; c++) begin
			b = list_head[c];
			n = 0;
			while (b != 0 && n < WALK_LIMIT) begin
				if (asize <= blk_size(b)) return b;
				b = mem_rd(b);
				n++;
			end
		end
		return 32'd0;
	endfunction

	function automatic void carve(input logic [31:0] bp, input logic [31:0] asize);
		logic [31:0] csize, rem, nb;
		csize = blk_size(bp);
		rem = csize - asize;
		pull_free(bp);
		if (rem > SPLIT_MIN) begin
			nb = bp + asize;
			mem_wr(bp - 32'd4, asize | 32'd1);
			mem_wr(bp + asize - 32'd8, asize | 32'd1);
			mem_wr(nb - 32'd4, rem);
			mem_wr(nb + rem - 32'd8, rem);
			push_free(nb, rem);
		end else begin
			mem_wr(bp - 32'd4, csize | 32'd1);
			mem_wr(bp + csize - 32'd8, csize | 32'd1);
		end
	endfunction

	function automatic void heap_reset();
		logic [31:0] unused;
		foreach (heap_mem[i]) heap_mem[i] = 32'd0;
		foreach (list_head[i]) list_head[i] = 32'd0;
		mem_wr(32'd4, 32'd9);
		mem_wr(32'd8, 32'd9);
		mem_wr(32'd12, 32'd1);
		heap_top = 32'd16;
		unused = grow_heap(CHUNK_BYTES);
	endfunction

	function automatic rsp_t serve(input req_t r);
		rsp_t o;
		logic [31:0] sz, asize, b, p, size, unused;
		o.addr = '0;
		o.status = STAT_OK;
		if (r.cmd == CMD_ALLOC) begin
			sz = {16'd0, r.req_size};
			if (sz == 0) begin
				o.status = STAT_ZERO;
			end else begin
				asize = (sz <= 8) ? 32'd16 : 8 * ((sz + 15) / 8);
				b = first_fit(asize);
				if (b == 0) b = grow_heap(asize > CHUNK_BYTES ? asize : CHUNK_BYTES);
				if (b == 0) begin
					o.status = STAT_FULL;
				end else begin
					carve(b, asize);
					o.addr = b[15:0];
				end
			end
		end else begin
			p = {16'd0, r.block_addr};
			if (p != 0) begin
				size = blk_size(p);
				mem_wr(p - 32'd4, size);
				mem_wr(p + size - 32'd8, size);
				push_free(p, blk_size(p));
				unused = merge_free(p);
			end
		end
		return o;
	endfunction

	task automatic report(input string what, input int exp_v, input int got_v);
		$display("mismatch @%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		heap_reset();
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (req_valid && req_ready) expected_rsp.push_back(serve(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					report("unexpected response, addr", 0, rsp.addr);
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.addr !== e.addr) report("addr", e.addr, rsp.addr);
					if (rsp.status !== e.status) report("status", e.status, rsp.status);
				end
			end
			pending = expected_rsp.size();
		end
	end
endmodule

/* tb/tb_segregated_free_list_allocator_unit.sv */
module tb_segregated_free_list_allocator_unit;
	import sfla_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// generous bound: slow frees, long list walks and receiver stalls
	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_ITEMS = 1030;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int errors, pending;
	int cycles = 0;
	int burst_left = 0;

	// payload offsets handed out and not yet given back
	logic [15:0] live_blocks [$];

	always #6 clk = ~clk;

	segregated_free_list_allocator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	tb_sfla_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.errors(errors), .pending(pending)
	);

	// timeout watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** segregated_free_list_allocator_unit: FAILED **");
			$finish;
		end
	end

	// collect granted blocks so frees only target live ones
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready && rsp.addr != 0) begin
			live_blocks.push_back(rsp.addr);
		end
	end

	// receiver: alternate between always ready, light and heavy stalls
	always @(posedge clk) begin
		int mode;
		mode = (cycles / 300) % 3;
		case (mode)
			0: begin
				rsp_ready <= 1'b1;
			end
			1: begin
				rsp_ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				rsp_ready <= ($urandom_range(0, 4) == 0);
			end
		endcase
	end

	// one transaction; valid stays up across a burst, drops for the gaps
	task automatic send(input req_t r);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk iff req_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
			                                          : $urandom_range(0, 7);
		end
	endtask

	task automatic alloc(input logic [15:0] n);
		req_t r;
		r.cmd = CMD_ALLOC;
		r.req_size = n;
		r.block_addr = 16'($urandom);
		send(r);
	endtask

	task automatic release_blk(input logic [15:0] a);
		req_t r;
		r.cmd = CMD_FREE;
		r.req_size = 16'($urandom);
		r.block_addr = a;
		send(r);
	endtask

	function automatic logic [15:0] take_live(input int idx);
		logic [15:0] a;
		a = live_blocks[idx];
		live_blocks.delete(idx);
		return a;
	endfunction

	// stop sending so the last transaction is not repeated while waiting
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		int pick, sel;
		logic [15:0] sz;
		logic [15:0] a;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rounding edges, first chunk miss, exhaustion
		alloc(16'd0);
		alloc(16'd1);
		alloc(16'd8);
		alloc(16'd9);
		alloc(16'd24);
		alloc(16'd25);
		alloc(16'd100);
		alloc(16'd300);
		alloc(16'hFFFF);
		release_blk(16'd0);
		drain();
		// coalescing: neither neighbor free, next free, neither again, both free
		release_blk(take_live(1));
		release_blk(take_live(0));
		release_blk(take_live(1));
		release_blk(take_live(0));
		alloc(16'd16);
		alloc(16'd40000);
		alloc(16'd30000);
		alloc(16'd5);
		drain();

		// random traffic
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (live_blocks.size() > 60) pick = 80;
			if (pick < 5) begin
				if (pick[0]) alloc(16'd0);
				else release_blk(16'd0);
			end else if (pick < 50 || live_blocks.size() == 0) begin
				sel = $urandom_range(0, 99);
				if (sel < 70) sz = 16'($urandom_range(1, 64));
				else if (sel < 95) sz = 16'($urandom_range(65, 1024));
				else sz = 16'($urandom);
				alloc(sz);
			end else begin
				a = take_live($urandom_range(0, live_blocks.size() - 1));
				// low two bits do not change the storage word
				if ($urandom_range(0, 9) == 0) a = a | 16'($urandom_range(1, 3));
				release_blk(a);
			end
		end

		req_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("** segregated_free_list_allocator_unit: PASSED **");
		end else begin
			$display("** segregated_free_list_allocator_unit: FAILED **");
		end
		$finish;
	end
endmodule
